// ===== sv/sampson_epipolar_distance_unit_defines.svh =====
// assertion macros for the sampson epipolar distance unit
`ifndef SAMPSON_EPIPOLAR_DISTANCE_UNIT_DEFINES_SVH
`define SAMPSON_EPIPOLAR_DISTANCE_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define SED_ASSERT_IMP(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("sed assertion failed");

// next-cycle implication, also checked through reset
`define SED_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) (pre) |=> (post)) \
      else $error("sed assertion failed");

`endif

// ===== sv/sed_pkg.sv =====
// shared constants and types of the sampson epipolar distance unit
package sed_pkg;
   localparam int COORD_WIDTH_DEFAULT = 24;
   localparam int COEF_WIDTH_DEFAULT  = 32;
   localparam int COORD_FRAC          = 8;
   localparam int OUT_FRAC            = 8;
   localparam int OUT_SHIFT           = 2 * COORD_FRAC - OUT_FRAC;
   localparam int QUOT_WIDTH          = 32;
   localparam int MUL_CHUNK           = 30;
   localparam int NUM_REGS            = 5;
   localparam int CSR_ADDR_WIDTH      = 6;
   localparam int CSR_DATA_WIDTH      = 64;
   localparam int SLOT_WIDTH          = 32;

   typedef enum logic [2:0] {
      REG_R0C0_R0C1 = 3'd0,
      REG_R0C2_R1C0 = 3'd1,
      REG_R1C1_R1C2 = 3'd2,
      REG_R2C0_R2C1 = 3'd3,
      REG_R2C2      = 3'd4
   } csr_reg_type;
endpackage

// ===== sv/sed_chan_if.sv =====
// item channel interfaces of the sampson epipolar distance unit
interface sed_req_if #(parameter int COORD_WIDTH = 24);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] first_u;
   logic signed [COORD_WIDTH-1:0] first_v;
   logic signed [COORD_WIDTH-1:0] second_u;
   logic signed [COORD_WIDTH-1:0] second_v;
   modport source (output valid, first_u, first_v, second_u, second_v, input ready);
   modport sink   (input valid, first_u, first_v, second_u, second_v, output ready);
endinterface

interface sed_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] distance_sq;
   logic        degenerate;
   modport source (output valid, distance_sq, degenerate, input ready);
   modport sink   (input valid, distance_sq, degenerate, output ready);
endinterface

// ===== sv/sed_mul.sv =====
// two-stage signed multiplier built from narrow partial products
module sed_mul #(
   parameter int AW = 32,
   parameter int BW = 24
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [AW-1:0]    a,
   input  logic signed [BW-1:0]    b,
   output logic signed [AW+BW-1:0] p
);
   import sed_pkg::*;

   localparam int CH = MUL_CHUNK;
   localparam int NA = (AW + CH - 1) / CH;
   localparam int NB = (BW + CH - 1) / CH;
   localparam int OW = AW + BW;

   logic signed [NA*CH:0]     a_x;
   logic signed [NB*CH:0]     b_x;
   logic signed [CH:0]        ca [NA];
   logic signed [CH:0]        cb [NB];
   logic signed [2*CH+1:0]    pp_ff [NA*NB];
   logic signed [OW-1:0]      sum_in;
   logic signed [OW-1:0]      p_ff;

   assign a_x = (NA*CH+1)'(a);
   assign b_x = (NB*CH+1)'(b);

   for (genvar i = 0; i < NA; i++) begin : g_ca
      if (i == NA - 1) begin : g_top
         assign ca[i] = a_x[i*CH +: CH+1];
      end else begin : g_low
         assign ca[i] = {1'b0, a_x[i*CH +: CH]};
      end
   end

   for (genvar j = 0; j < NB; j++) begin : g_cb
      if (j == NB - 1) begin : g_top
         assign cb[j] = b_x[j*CH +: CH+1];
      end else begin : g_low
         assign cb[j] = {1'b0, b_x[j*CH +: CH]};
      end
   end

   for (genvar i = 0; i < NA; i++) begin : g_pi
      for (genvar j = 0; j < NB; j++) begin : g_pj
         always_ff @(posedge clock) begin
            if (en) pp_ff[i*NB+j] <= ca[i] * cb[j];
         end
      end
   end

   // shifted partial products, exact modulo the product width
   always_comb begin
      sum_in = '0;
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            sum_in = sum_in + (OW'(pp_ff[i*NB+j]) <<< ((i + j) * CH));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) p_ff <= sum_in;
   end

   assign p = p_ff;
endmodule

// ===== sv/sed_div.sv =====
// saturating restoring divider, one quotient bit per stage
module sed_div #(
   parameter int NW = 168,
   parameter int DW = 118
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic [NW-1:0]                 num,
   input  logic [DW-1:0]                 den,
   output logic [sed_pkg::QUOT_WIDTH-1:0] quot,
   output logic                          sat
);
   import sed_pkg::*;

   localparam int QW = QUOT_WIDTH;
   localparam int DS = DW + OUT_SHIFT + QW;
   localparam int WW = ((NW > DS) ? NW : DS) + 1;

   logic [WW-1:0] num_w;
   logic [WW-1:0] den_w;
   logic          sat_in;
   logic [WW-1:0] rem_ff [QW+1];
   logic [WW-1:0] den_ff [QW+1];
   logic [QW-1:0] q_ff   [QW+1];
   logic          sat_ff [QW+1];

   assign num_w  = WW'(num);
   assign den_w  = WW'(den) << OUT_SHIFT;
   assign sat_in = (den == '0) || (num_w >= (den_w << QW));

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= num_w;
         den_ff[0] <= den_w;
         q_ff[0]   <= sat_in ? '1 : '0;
         sat_ff[0] <= sat_in;
      end
   end

   for (genvar s = 1; s <= QW; s++) begin : g_stage
      logic [WW-1:0] t;
      logic          ge;
      assign t  = den_ff[s-1] << (QW - s);
      assign ge = !sat_ff[s-1] && (rem_ff[s-1] >= t);
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= ge ? (rem_ff[s-1] - t) : rem_ff[s-1];
            den_ff[s] <= den_ff[s-1];
            q_ff[s]   <= q_ff[s-1] | (QW'(ge) << (QW - s));
            sat_ff[s] <= sat_ff[s-1];
         end
      end
   end

   assign quot = q_ff[QW];
   assign sat  = sat_ff[QW];
endmodule

// ===== sv/sampson_epipolar_distance_unit.sv =====
// top level of the squared sampson distance pipeline
// The unit scores one point correspondence per clock against a 3x3 matrix
// held in five configuration registers, returning the squared sampson
// distance n^2/d as unsigned q24.8 with a degenerate flag that marks a zero
// denominator or a saturated result. Every item passes 41 register stages:
// three multiplier groups (matrix times point, line products and squares,
// residual square), two adder stages and a 33-stage one-bit-per-stage
// divider. A new item enters every cycle; the whole pipe advances together
// and freezes only while a result sits in the output stage unaccepted.
// Configuration must be written only while the pipe is empty; the unit
// itself does not enforce this.
module sampson_epipolar_distance_unit #(
   parameter int COORD_WIDTH = sed_pkg::COORD_WIDTH_DEFAULT,
   parameter int COEF_WIDTH  = sed_pkg::COEF_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   sed_req_if.sink                             req,
   sed_rsp_if.source                           rsp,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [sed_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [sed_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [sed_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                pready
);
   import sed_pkg::*;
`include "sampson_epipolar_distance_unit_defines.svh"

   // widths of the exact intermediates
   localparam int PW  = COORD_WIDTH + COEF_WIDTH;     // coefficient times coordinate
   localparam int LW  = PW + 2;                       // line terms and column dots
   localparam int NNW = COORD_WIDTH + LW + 2;         // residual
   localparam int DW  = 2 * LW + 2;                   // denominator
   localparam int NW  = 2 * NNW;                      // residual squared
   localparam int MUL_LAT = 2;
   localparam int LAT = 3 * MUL_LAT + 2 + QUOT_WIDTH + 1;

   // configuration registers
   logic [CSR_DATA_WIDTH-1:0] coef_ff [NUM_REGS];
   logic                      wr_en;
   csr_reg_type               wr_idx;

   assign pready = 1'b1;
   assign wr_idx = csr_reg_type'(paddr[5:3]);
   assign wr_en  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_REGS; r++) coef_ff[r] <= '0;
      end else if (wr_en) begin
         unique case (wr_idx)
            REG_R0C0_R0C1: coef_ff[0] <= pwdata;
            REG_R0C2_R1C0: coef_ff[1] <= pwdata;
            REG_R1C1_R1C2: coef_ff[2] <= pwdata;
            REG_R2C0_R2C1: coef_ff[3] <= pwdata;
            REG_R2C2:      coef_ff[4] <= {32'd0, pwdata[31:0]};
            default: ;  // writes beyond the register list are dropped
         endcase
      end
   end

   always_comb begin
      unique case (wr_idx)
         REG_R0C0_R0C1: prdata = coef_ff[0];
         REG_R0C2_R1C0: prdata = coef_ff[1];
         REG_R1C1_R1C2: prdata = coef_ff[2];
         REG_R2C0_R2C1: prdata = coef_ff[3];
         REG_R2C2:      prdata = coef_ff[4];
         default:       prdata = '0;
      endcase
   end

   // matrix entries, row major, low bits of each 32-bit slot
   logic signed [COEF_WIDTH-1:0] f [9];
   for (genvar k = 0; k < 9; k++) begin : g_coef
      assign f[k] = coef_ff[k/2][(k%2)*SLOT_WIDTH +: COEF_WIDTH];
   end

   // pipeline control: everything advances unless the output stage is stuck
   logic           en;
   logic [LAT-1:0] vld_ff;

   assign en        = !vld_ff[LAT-1] || rsp.ready;
   assign req.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req.valid};
      end
   end

   // group 1: matrix times first point and second point times columns
   logic signed [COEF_WIDTH-1:0]  ma [10];
   logic signed [COORD_WIDTH-1:0] mb [10];
   logic signed [PW-1:0]          mp [10];

   assign ma = '{f[0], f[1], f[3], f[4], f[6], f[7], f[0], f[3], f[1], f[4]};
   assign mb = '{req.first_u, req.first_v, req.first_u, req.first_v,
                 req.first_u, req.first_v, req.second_u, req.second_v,
                 req.second_u, req.second_v};

   for (genvar m = 0; m < 10; m++) begin : g_mul1
      sed_mul #(.AW(COEF_WIDTH), .BW(COORD_WIDTH)) u_mul (
         .clock (clock),
         .en    (en),
         .a     (ma[m]),
         .b     (mb[m]),
         .p     (mp[m])
      );
   end

   // second point rides along until the line products
   logic signed [COORD_WIDTH-1:0] yu_ff [MUL_LAT+1];
   logic signed [COORD_WIDTH-1:0] yv_ff [MUL_LAT+1];

   always_ff @(posedge clock) begin
      if (en) begin
         yu_ff[0] <= req.second_u;
         yv_ff[0] <= req.second_v;
         for (int s = 1; s <= MUL_LAT; s++) begin
            yu_ff[s] <= yu_ff[s-1];
            yv_ff[s] <= yv_ff[s-1];
         end
      end
   end

   // epipolar line and column dots, homogeneous one is 1 << COORD_FRAC
   logic signed [LW-1:0] lx_ff, ly_ff, lz_ff, c0_ff, c1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         lx_ff <= LW'(mp[0]) + LW'(mp[1]) + (LW'(f[2]) <<< COORD_FRAC);
         ly_ff <= LW'(mp[2]) + LW'(mp[3]) + (LW'(f[5]) <<< COORD_FRAC);
         lz_ff <= LW'(mp[4]) + LW'(mp[5]) + (LW'(f[8]) <<< COORD_FRAC);
         c0_ff <= LW'(mp[6]) + LW'(mp[7]) + (LW'(f[6]) <<< COORD_FRAC);
         c1_ff <= LW'(mp[8]) + LW'(mp[9]) + (LW'(f[7]) <<< COORD_FRAC);
      end
   end

   // group 2: residual terms and the four squares
   logic signed [COORD_WIDTH+LW-1:0] pyx, pyy;
   logic signed [2*LW-1:0]           sq [4];
   logic signed [LW-1:0]             sqa [4];
   logic signed [LW-1:0]             lz_d_ff [MUL_LAT];

   assign sqa = '{lx_ff, ly_ff, c0_ff, c1_ff};

   sed_mul #(.AW(COORD_WIDTH), .BW(LW)) u_mul_yx (
      .clock (clock), .en (en), .a (yu_ff[MUL_LAT]), .b (lx_ff), .p (pyx)
   );
   sed_mul #(.AW(COORD_WIDTH), .BW(LW)) u_mul_yy (
      .clock (clock), .en (en), .a (yv_ff[MUL_LAT]), .b (ly_ff), .p (pyy)
   );

   for (genvar m = 0; m < 4; m++) begin : g_sq
      sed_mul #(.AW(LW), .BW(LW)) u_mul (
         .clock (clock), .en (en), .a (sqa[m]), .b (sqa[m]), .p (sq[m])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lz_d_ff[0] <= lz_ff;
         for (int s = 1; s < MUL_LAT; s++) lz_d_ff[s] <= lz_d_ff[s-1];
      end
   end

   // residual and denominator (the denominator is never negative)
   logic signed [NNW-1:0] n_ff;
   logic        [DW-1:0]  d_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff <= NNW'(pyx) + NNW'(pyy) + (NNW'(lz_d_ff[MUL_LAT-1]) <<< COORD_FRAC);
         d_ff <= DW'(sq[0]) + DW'(sq[1]) + DW'(sq[2]) + DW'(sq[3]);
      end
   end

   // group 3: residual squared, denominator waits alongside
   logic signed [NW-1:0] nsq;
   logic        [DW-1:0] d_d_ff [MUL_LAT];

   sed_mul #(.AW(NNW), .BW(NNW)) u_mul_nn (
      .clock (clock), .en (en), .a (n_ff), .b (n_ff), .p (nsq)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         d_d_ff[0] <= d_ff;
         for (int s = 1; s < MUL_LAT; s++) d_d_ff[s] <= d_d_ff[s-1];
      end
   end

   // divider, its last stage is the output register
   logic [QUOT_WIDTH-1:0] quot;
   logic                  sat;

   sed_div #(.NW(NW), .DW(DW)) u_div (
      .clock (clock),
      .en    (en),
      .num   (nsq),
      .den   (d_d_ff[MUL_LAT-1]),
      .quot  (quot),
      .sat   (sat)
   );

   assign rsp.valid       = vld_ff[LAT-1];
   assign rsp.distance_sq = quot;
   assign rsp.degenerate  = sat;

   // checks
   `SED_ASSERT_NEXT(a_reset_empties, reset, !rsp.valid)
   `SED_ASSERT_IMP(a_degenerate_saturates, rsp.valid && rsp.degenerate, rsp.distance_sq == '1)
   `SED_ASSERT_NEXT(a_accept_enters_pipe, req.valid && req.ready && !reset, vld_ff[0])
   `SED_ASSERT_IMP(a_stall_only_when_full, !req.ready, rsp.valid && !rsp.ready)
endmodule

// ===== tb/sampson_epipolar_distance_unit_tb.sv =====
// self-checking testbench of the squared sampson distance unit
module sampson_epipolar_distance_unit_tb;
   import sed_pkg::*;

   localparam int CW = 24;

   typedef struct packed {
      logic signed [CW-1:0] first_u;
      logic signed [CW-1:0] first_v;
      logic signed [CW-1:0] second_u;
      logic signed [CW-1:0] second_v;
   } corr_type;

   typedef struct packed {
      logic [31:0] distance_sq;
      logic        degenerate;
   } dist_type;

   logic clock = 0;
   logic reset = 1;

   logic                      psel = 0;
   logic                      penable = 0;
   logic                      pwrite = 0;
   logic [CSR_ADDR_WIDTH-1:0] paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   sed_req_if #(.COORD_WIDTH(CW)) req_if ();
   sed_rsp_if rsp_if ();

   sampson_epipolar_distance_unit #(.COORD_WIDTH(CW), .COEF_WIDTH(32)) DUT (
      .clock(clock), .reset(reset), .req(req_if.sink), .rsp(rsp_if.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // matrix copy kept by the predictor, one 32-bit slot per entry
   logic [63:0] matrix_regs [NUM_REGS];

   corr_type pending_corrs[$];
   dist_type expected_dists[$];
   int    error_count = 0;
   bit    quiet = 0;       // no idling in the last part of the run
   bit    hold_sender = 0;
   int    send_gap = 0;
   int    sink_stall = 0;

   task automatic report_mismatch(input string what);
      $display("mismatch: %s", what);
      error_count++;
   endtask

   function automatic logic signed [31:0] entry(input int k);
      logic [63:0] r;
      r = matrix_regs[k / 2];
      return (k % 2) ? r[63:32] : r[31:0];
   endfunction

   // exact wide arithmetic, then floor of n^2/(d<<8) with saturation
   function automatic dist_type predict_distance(input corr_type c);
      logic signed [255:0] f [9];
      logic signed [255:0] xu, xv, yu, yv, one, lx, ly, lz, n, c0, c1, d, num, den;
      dist_type r;
      for (int k = 0; k < 9; k++) f[k] = entry(k);
      xu = c.first_u; xv = c.first_v; yu = c.second_u; yv = c.second_v;
      one = 256;
      lx = f[0] * xu + f[1] * xv + f[2] * one;
      ly = f[3] * xu + f[4] * xv + f[5] * one;
      lz = f[6] * xu + f[7] * xv + f[8] * one;
      n = yu * lx + yv * ly + one * lz;
      c0 = yu * f[0] + yv * f[3] + one * f[6];
      c1 = yu * f[1] + yv * f[4] + one * f[7];
      d = c0 * c0 + c1 * c1 + lx * lx + ly * ly;
      num = n * n;
      den = d <<< OUT_SHIFT;
      if (d == 0 || $unsigned(num) >= $unsigned(den <<< 32)) begin
         r.distance_sq = 32'hFFFF_FFFF;
         r.degenerate = 1'b1;
      end else begin
         r.distance_sq = 32'($unsigned(num) / $unsigned(den));
         r.degenerate = 1'b0;
      end
      return r;
   endfunction

   // driver: presents queued items, random gaps between them
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.first_u <= '0;
         req_if.first_v <= '0;
         req_if.second_u <= '0;
         req_if.second_v <= '0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_dists.push_back(predict_distance(pending_corrs.pop_front()));
         end
         if (req_if.valid && !req_if.ready) begin
            // hold the item
         end else if (send_gap > 0) begin
            send_gap--;
            req_if.valid <= 1'b0;
         end else if (pending_corrs.size() > 0 && !hold_sender) begin
            req_if.valid <= 1'b1;
            {req_if.first_u, req_if.first_v, req_if.second_u, req_if.second_v}
               <= pending_corrs[0];
            if (!quiet && $urandom_range(0, 15) == 0) send_gap = $urandom_range(1, 18);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // monitor: checks each result and stalls the result side at random
   always @(posedge clock) begin
      dist_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_dists.size() == 0) begin
               report_mismatch("result with no item outstanding");
            end else begin
               want = expected_dists.pop_front();
               if (rsp_if.distance_sq !== want.distance_sq)
                  report_mismatch($sformatf("distance_sq %h, want %h",
                                            rsp_if.distance_sq, want.distance_sq));
               if (rsp_if.degenerate !== want.degenerate)
                  report_mismatch($sformatf("degenerate %b, want %b",
                                            rsp_if.degenerate, want.degenerate));
            end
         end
         if (sink_stall > 0) begin
            sink_stall--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if (!quiet && $urandom_range(0, 15) == 0) sink_stall = $urandom_range(1, 18);
         end
      end
   end

   // register write over the apb port, setup then access
   task automatic write_csr(input csr_reg_type idx, input logic [63:0] value);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= CSR_ADDR_WIDTH'(8 * int'(idx)); pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      matrix_regs[idx] = (idx == REG_R2C2) ? {32'd0, value[31:0]} : value;
   endtask

   task automatic wait_drained();
      while (pending_corrs.size() > 0 || req_if.valid || expected_dists.size() > 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coef(input int mode);
      case (mode)
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
         2: return 32'h7FFF_FFFF;
         default: return 32'h8000_0000;
      endcase
   endfunction

   task automatic load_matrix(input int mode);
      write_csr(REG_R0C0_R0C1, {rand_coef(mode), rand_coef(mode)});
      write_csr(REG_R0C2_R1C0, {rand_coef(mode), rand_coef(mode)});
      write_csr(REG_R1C1_R1C2, {rand_coef(mode), rand_coef(mode)});
      write_csr(REG_R2C0_R2C1, {rand_coef(mode), rand_coef(mode)});
      write_csr(REG_R2C2, {32'($urandom()), rand_coef(mode)});
   endtask

   function automatic logic [CW-1:0] rand_coord(input bit narrow);
      if (narrow) return CW'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
      return CW'($urandom());
   endfunction

   task automatic queue_random(input int count);
      corr_type c;
      bit narrow;
      for (int i = 0; i < count; i++) begin
         narrow = ($urandom_range(0, 3) != 0);
         c.first_u = rand_coord(narrow);
         c.first_v = rand_coord(narrow);
         c.second_u = rand_coord(narrow);
         c.second_v = rand_coord(narrow);
         pending_corrs.push_back(c);
      end
   endtask

   initial begin
      logic signed [CW-1:0] lo, hi;
      lo = {1'b1, {(CW-1){1'b0}}};
      hi = {1'b0, {(CW-1){1'b1}}};
      for (int i = 0; i < NUM_REGS; i++) matrix_regs[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // zero matrix after reset: every denominator is zero
      pending_corrs.push_back('{0, 0, 0, 0});
      pending_corrs.push_back('{hi, lo, 256, -256});
      wait_drained();

      // sparse matrix with two nonzero entries: ordinary and saturating distances
      write_csr(REG_R0C0_R0C1, {32'h0000_0000, 32'h0000_0000});
      write_csr(REG_R0C2_R1C0, {32'h0000_0000, 32'hFF00_0000});
      write_csr(REG_R1C1_R1C2, {32'h0000_0000, 32'h0000_0000});
      write_csr(REG_R2C0_R2C1, {32'h0000_0000, 32'h0000_0000});
      write_csr(REG_R2C2, 64'h0000_0000_0100_0000);
      pending_corrs.push_back('{0, 0, 0, 0});
      pending_corrs.push_back('{256, 512, 256, 768});
      pending_corrs.push_back('{hi, hi, hi, hi});
      pending_corrs.push_back('{lo, lo, lo, lo});
      pending_corrs.push_back('{lo, hi, hi, lo});
      pending_corrs.push_back('{-1, -1, 1, 1});
      pending_corrs.push_back('{0, 100, 0, 90000});   // large second v does not saturate
      queue_random(12);
      wait_drained();

      // extreme matrices, then random ones of various scales
      for (int phase = 0; phase < 8; phase++) begin
         load_matrix(phase < 2 ? phase + 2 : phase % 2);
         queue_random(phase == 3 ? 60 : 220);
         if (phase == 3) begin
            // sender stops mid-stream and waits until the pipe has emptied
            wait (pending_corrs.size() <= 40);
            hold_sender = 1;
            wait (expected_dists.size() == 0 && !req_if.valid);
            @(posedge clock);
            hold_sender = 0;
         end
         if (phase == 7) quiet = 1;
         wait_drained();
      end

      if (error_count == 0) begin
         $display("sampson_epipolar_distance_unit_tb passed");
      end else begin
         $display("sampson_epipolar_distance_unit_tb failed");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("sampson_epipolar_distance_unit_tb failed");
      $finish;
   end
endmodule

// ===== sampson_epipolar_distance_unit.f =====
+incdir+sv
sv/sed_pkg.sv
sv/sed_chan_if.sv
sv/sed_mul.sv
sv/sed_div.sv
sv/sampson_epipolar_distance_unit.sv
tb/sampson_epipolar_distance_unit_tb.sv
